[hdl/web_mercator_projection_unit_macros.svh]
// assertion macros for the web mercator projection unit
// used by the top level only, no other dependencies
`ifndef WEB_MERCATOR_PROJECTION_UNIT_MACROS_SVH
`define WEB_MERCATOR_PROJECTION_UNIT_MACROS_SVH

// same-cycle implication
`define WMP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WMP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/wmp_pkg.sv]
// types, constants and arithmetic helpers for the web mercator projection unit
// no dependencies; used by web_mercator_projection_unit
package wmp_pkg;

    localparam int unsigned ANGLE_FRAC_BITS = 22;
    localparam int unsigned METER_FRAC_BITS = 8;
    localparam int unsigned QF              = 60;

    localparam logic [63:0] ONE_Q       = 64'd1 << QF;
    localparam logic [63:0] LN2_Q60     = 64'h0B17217F7D1CF79B;
    localparam logic [63:0] DEG2RAD_Q62 = 64'd80489105089745809;
    localparam logic [63:0] MPD_Q32     = 64'd478113572364483;
    localparam logic [63:0] LATLIM_Q40  = 64'd93514705048871;
    localparam logic [63:0] EARTH_R     = 64'd6378137;
    localparam logic [63:0] OUT_MAX     = (64'd1 << 33) - 64'd1;
    localparam logic [63:0] LAT_LIM     = LATLIM_Q40 >> (40 - ANGLE_FRAC_BITS);

    localparam int unsigned X_SHIFT   = ANGLE_FRAC_BITS + 32 - METER_FRAC_BITS - 1;
    localparam int unsigned PHI_SHIFT = ANGLE_FRAC_BITS + 2;
    localparam int unsigned Y_SHIFT   = QF - METER_FRAC_BITS - 1;

    localparam int unsigned TRIG_TERMS  = 13;
    localparam int unsigned ATANH_TERMS = 24;
    localparam int unsigned DIV_STEPS   = 2;

    // pipeline stage map
    localparam int unsigned ST_MAG     = 0;
    localparam int unsigned ST_PP0     = 1;
    localparam int unsigned ST_PHI     = 2;
    localparam int unsigned ST_SQP     = 3;
    localparam int unsigned ST_SQ      = 4;
    localparam int unsigned ST_TRIG    = 5;
    localparam int unsigned TRIG_STG   = 5;
    localparam int unsigned ST_NRM     = ST_TRIG + TRIG_TERMS * TRIG_STG;
    localparam int unsigned ST_NRM2    = ST_NRM + 1;
    localparam int unsigned ST_LNSET   = ST_NRM + 2;
    localparam int unsigned ST_DIV     = ST_NRM + 3;
    localparam int unsigned DIV_STAGES = QF / DIV_STEPS;
    localparam int unsigned ST_Z2P     = ST_DIV + DIV_STAGES;
    localparam int unsigned ST_Z2      = ST_Z2P + 1;
    localparam int unsigned ST_ATH     = ST_Z2P + 2;
    localparam int unsigned ATH_STG    = 3;
    localparam int unsigned ST_G       = ST_ATH + ATANH_TERMS * ATH_STG;
    localparam int unsigned ST_YP      = ST_G + 1;
    localparam int unsigned ST_Y       = ST_G + 2;
    localparam int unsigned NST        = ST_Y + 1;

    typedef struct packed {
        logic [63:0] p11;
        logic [63:0] p10;
        logic [63:0] p01;
        logic [63:0] p00;
    } pp_t;

    typedef struct packed {
        logic [63:0] t;    // running term, remainder or power
        logic [63:0] acc;  // running sum or quotient
        logic [63:0] aux;  // divisor or squared factor
        logic [63:0] q;    // product or dividend
        logic [63:0] e;    // quotient estimate
        pp_t         pm;   // partial products of the multiply
        pp_t         pd;   // partial products of the reciprocal
    } lane_t;

    typedef struct packed {
        logic             lon_neg;
        logic             lat_neg;
        logic             clamped;
        logic [32:0]      x_mag;
        logic [63:0]      sq;
        logic [63:0]      kln2;
        lane_t [1:0]      ln;
    } ctx_t;

    function automatic pp_t pp_calc(input logic [63:0] a, input logic [63:0] b);
        pp_t p;
        p.p00 = 64'(a[31:0]) * 64'(b[31:0]);
        p.p01 = 64'(a[31:0]) * 64'(b[63:32]);
        p.p10 = 64'(a[63:32]) * 64'(b[31:0]);
        p.p11 = 64'(a[63:32]) * 64'(b[63:32]);
        return p;
    endfunction

    function automatic logic [127:0] pp_sum(input pp_t p);
        return 128'(p.p00) + (128'(p.p01) << 32) + (128'(p.p10) << 32)
             + (128'(p.p11) << 64);
    endfunction

    // floor of product over 2^s, all ones on overflow
    function automatic logic [63:0] mul_shr(input pp_t p, input int unsigned s);
        logic [127:0] f;
        f = pp_sum(p);
        if ((f[127:64] >> s) != 64'd0) begin
            return '1;
        end
        f = f >> s;
        return f[63:0];
    endfunction

    // half-up rounding of a value with one extra fraction bit, then saturation
    function automatic logic [32:0] rnd_sat(input logic [63:0] v);
        logic [63:0] r;
        if (v == '1) begin
            r = v;
        end else begin
            r = (v >> 1) + {63'd0, v[0]};
        end
        if (r > OUT_MAX) begin
            r = OUT_MAX;
        end
        return r[32:0];
    endfunction

endpackage

[hdl/web_mercator_projection_unit.sv]
// web mercator projection: longitude/latitude in degrees to easting/northing in meters
// depends on wmp_pkg and web_mercator_projection_unit_macros.svh
// depth: 180 datapath stages from input accept to result, then the output register
// throughput: one item per cycle; the whole pipeline stalls only while the output is held
// sin/cos series, two 60-step restoring dividers and the atanh series set the depth
// reset (aresetn low, synchronous) clears all valid bits; payload registers are not reset
`include "web_mercator_projection_unit_macros.svh"

module web_mercator_projection_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // lon_deg [30:0], lat_deg [60:31], zeros above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // x_meters [33:0], y_meters [67:34], zeros above
    output logic        m_tuser    // lat_clamped
);

    wmp_pkg::ctx_t pipe_reg  [wmp_pkg::NST];
    wmp_pkg::ctx_t pipe_next [wmp_pkg::NST];
    logic [wmp_pkg::NST-1:0] vld_reg, vld_next;
    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;
    logic        adv;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[wmp_pkg::NST-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= vld_next;
            m_tvalid_reg <= vld_reg[wmp_pkg::NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pipe_reg    <= pipe_next;
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    // magnitudes and latitude clamp
    always_comb begin
        logic [30:0] lon;
        logic [29:0] lat;
        logic [63:0] lon_mag, lat_mag;
        pipe_next[wmp_pkg::ST_MAG] = '0;
        lon = s_tdata[30:0];
        lat = s_tdata[60:31];
        lon_mag = lon[30] ? (64'h8000_0000 - {33'd0, lon}) : {33'd0, lon};
        lat_mag = lat[29] ? (64'h4000_0000 - {34'd0, lat}) : {34'd0, lat};
        pipe_next[wmp_pkg::ST_MAG].lon_neg = lon[30];
        pipe_next[wmp_pkg::ST_MAG].lat_neg = lat[29];
        if (lat_mag > wmp_pkg::LAT_LIM) begin
            lat_mag = wmp_pkg::LAT_LIM;
            pipe_next[wmp_pkg::ST_MAG].clamped = 1'b1;
        end
        pipe_next[wmp_pkg::ST_MAG].ln[0].t = lon_mag;
        pipe_next[wmp_pkg::ST_MAG].ln[1].t = lat_mag;
    end

    always_comb begin
        pipe_next[wmp_pkg::ST_PP0] = pipe_reg[wmp_pkg::ST_PP0-1];
        pipe_next[wmp_pkg::ST_PP0].ln[0].pm =
            wmp_pkg::pp_calc(pipe_reg[wmp_pkg::ST_PP0-1].ln[0].t, wmp_pkg::MPD_Q32);
        pipe_next[wmp_pkg::ST_PP0].ln[1].pm =
            wmp_pkg::pp_calc(pipe_reg[wmp_pkg::ST_PP0-1].ln[1].t, wmp_pkg::DEG2RAD_Q62);
    end

    // easting done here; phi seeds the sin and cos lanes
    always_comb begin
        logic [63:0] phi;
        pipe_next[wmp_pkg::ST_PHI] = pipe_reg[wmp_pkg::ST_PHI-1];
        pipe_next[wmp_pkg::ST_PHI].x_mag = wmp_pkg::rnd_sat(
            wmp_pkg::mul_shr(pipe_reg[wmp_pkg::ST_PHI-1].ln[0].pm, wmp_pkg::X_SHIFT));
        phi = wmp_pkg::mul_shr(pipe_reg[wmp_pkg::ST_PHI-1].ln[1].pm, wmp_pkg::PHI_SHIFT);
        pipe_next[wmp_pkg::ST_PHI].ln[0].t   = phi;
        pipe_next[wmp_pkg::ST_PHI].ln[0].acc = phi;
        pipe_next[wmp_pkg::ST_PHI].ln[1].t   = wmp_pkg::ONE_Q;
        pipe_next[wmp_pkg::ST_PHI].ln[1].acc = wmp_pkg::ONE_Q;
    end

    always_comb begin
        pipe_next[wmp_pkg::ST_SQP] = pipe_reg[wmp_pkg::ST_SQP-1];
        pipe_next[wmp_pkg::ST_SQP].ln[0].pm = wmp_pkg::pp_calc(
            pipe_reg[wmp_pkg::ST_SQP-1].ln[0].t, pipe_reg[wmp_pkg::ST_SQP-1].ln[0].t);
    end

    always_comb begin
        pipe_next[wmp_pkg::ST_SQ] = pipe_reg[wmp_pkg::ST_SQ-1];
        pipe_next[wmp_pkg::ST_SQ].sq =
            wmp_pkg::mul_shr(pipe_reg[wmp_pkg::ST_SQ-1].ln[0].pm, wmp_pkg::QF);
    end

    // sin on lane 0, cos on lane 1, five stages per series term
    for (genvar gk = 0; gk < wmp_pkg::TRIG_TERMS; gk++) begin : g_trig
        localparam int unsigned KK   = gk + 1;
        localparam int unsigned DS   = (2 * KK) * (2 * KK + 1);
        localparam int unsigned DC   = (2 * KK - 1) * (2 * KK);
        localparam logic [63:0] RS   = 64'((128'd1 << 64) / DS);
        localparam logic [63:0] RC   = 64'((128'd1 << 64) / DC);
        localparam int unsigned BASE = wmp_pkg::ST_TRIG + gk * wmp_pkg::TRIG_STG;

        always_comb begin
            pipe_next[BASE] = pipe_reg[BASE-1];
            for (int l = 0; l < 2; l++) begin
                pipe_next[BASE].ln[l].pm =
                    wmp_pkg::pp_calc(pipe_reg[BASE-1].ln[l].t, pipe_reg[BASE-1].sq);
            end
        end

        always_comb begin
            pipe_next[BASE+1] = pipe_reg[BASE];
            for (int l = 0; l < 2; l++) begin
                pipe_next[BASE+1].ln[l].q =
                    wmp_pkg::mul_shr(pipe_reg[BASE].ln[l].pm, wmp_pkg::QF);
            end
        end

        always_comb begin
            pipe_next[BASE+2] = pipe_reg[BASE+1];
            pipe_next[BASE+2].ln[0].pd = wmp_pkg::pp_calc(pipe_reg[BASE+1].ln[0].q, RS);
            pipe_next[BASE+2].ln[1].pd = wmp_pkg::pp_calc(pipe_reg[BASE+1].ln[1].q, RC);
        end

        always_comb begin
            logic [127:0] f;
            pipe_next[BASE+3] = pipe_reg[BASE+2];
            for (int l = 0; l < 2; l++) begin
                f = wmp_pkg::pp_sum(pipe_reg[BASE+2].ln[l].pd);
                pipe_next[BASE+3].ln[l].e = f[127:64];
            end
        end

        // quotient correction and accumulation
        always_comb begin
            logic [63:0] d, qt, rem;
            pipe_next[BASE+4] = pipe_reg[BASE+3];
            for (int l = 0; l < 2; l++) begin
                d   = (l == 0) ? 64'(DS) : 64'(DC);
                rem = pipe_reg[BASE+3].ln[l].q - pipe_reg[BASE+3].ln[l].e * d;
                qt  = pipe_reg[BASE+3].ln[l].e + {63'd0, rem >= d};
                pipe_next[BASE+4].ln[l].t = qt;
                if (KK % 2 == 1) begin
                    pipe_next[BASE+4].ln[l].acc = pipe_reg[BASE+3].ln[l].acc - qt;
                end else begin
                    pipe_next[BASE+4].ln[l].acc = pipe_reg[BASE+3].ln[l].acc + qt;
                end
            end
        end
    end

    // cosine normalization, coarse shifts; shift count kept in kln2; lane 0 gets 1+sin
    always_comb begin
        logic [63:0] v;
        logic [6:0]  k;
        pipe_next[wmp_pkg::ST_NRM] = pipe_reg[wmp_pkg::ST_NRM-1];
        v = pipe_reg[wmp_pkg::ST_NRM-1].ln[1].acc;
        if (v == 64'd0) begin
            v = 64'd1;
        end
        k = 7'd0;
        for (int s = 5; s >= 3; s--) begin
            if ((v >> (61 - (1 << s))) == 64'd0) begin
                v = v << (1 << s);
                k = k + 7'(1 << s);
            end
        end
        pipe_next[wmp_pkg::ST_NRM].ln[0].t = wmp_pkg::ONE_Q + pipe_reg[wmp_pkg::ST_NRM-1].ln[0].acc;
        pipe_next[wmp_pkg::ST_NRM].ln[1].t = v;
        pipe_next[wmp_pkg::ST_NRM].kln2    = {57'd0, k};
    end

    always_comb begin
        logic [63:0] v;
        logic [6:0]  k;
        pipe_next[wmp_pkg::ST_NRM2] = pipe_reg[wmp_pkg::ST_NRM2-1];
        v = pipe_reg[wmp_pkg::ST_NRM2-1].ln[1].t;
        k = pipe_reg[wmp_pkg::ST_NRM2-1].kln2[6:0];
        for (int s = 2; s >= 0; s--) begin
            if ((v >> (61 - (1 << s))) == 64'd0) begin
                v = v << (1 << s);
                k = k + 7'(1 << s);
            end
        end
        pipe_next[wmp_pkg::ST_NRM2].ln[1].t = v;
        pipe_next[wmp_pkg::ST_NRM2].kln2    = {57'd0, k};
    end

    // ln setup: numerator m-1, divisor m+1
    always_comb begin
        logic [63:0] m;
        pipe_next[wmp_pkg::ST_LNSET] = pipe_reg[wmp_pkg::ST_LNSET-1];
        pipe_next[wmp_pkg::ST_LNSET].kln2 =
            {57'd0, pipe_reg[wmp_pkg::ST_LNSET-1].kln2[6:0]} * wmp_pkg::LN2_Q60;
        for (int l = 0; l < 2; l++) begin
            m = pipe_reg[wmp_pkg::ST_LNSET-1].ln[l].t;
            pipe_next[wmp_pkg::ST_LNSET].ln[l].t   = m - wmp_pkg::ONE_Q;
            pipe_next[wmp_pkg::ST_LNSET].ln[l].aux = m + wmp_pkg::ONE_Q;
            pipe_next[wmp_pkg::ST_LNSET].ln[l].acc = 64'd0;
        end
    end

    // restoring division, two quotient bits per stage
    for (genvar gd = 0; gd < wmp_pkg::DIV_STAGES; gd++) begin : g_div
        localparam int unsigned SI = wmp_pkg::ST_DIV + gd;
        always_comb begin
            logic [63:0] r, z;
            pipe_next[SI] = pipe_reg[SI-1];
            for (int l = 0; l < 2; l++) begin
                r = pipe_reg[SI-1].ln[l].t;
                z = pipe_reg[SI-1].ln[l].acc;
                for (int st = 0; st < wmp_pkg::DIV_STEPS; st++) begin
                    r = {r[62:0], 1'b0};
                    z = {z[62:0], 1'b0};
                    if (r >= pipe_reg[SI-1].ln[l].aux) begin
                        r    = r - pipe_reg[SI-1].ln[l].aux;
                        z[0] = 1'b1;
                    end
                end
                pipe_next[SI].ln[l].t   = r;
                pipe_next[SI].ln[l].acc = z;
            end
        end
    end

    always_comb begin
        pipe_next[wmp_pkg::ST_Z2P] = pipe_reg[wmp_pkg::ST_Z2P-1];
        for (int l = 0; l < 2; l++) begin
            pipe_next[wmp_pkg::ST_Z2P].ln[l].pm = wmp_pkg::pp_calc(
                pipe_reg[wmp_pkg::ST_Z2P-1].ln[l].acc, pipe_reg[wmp_pkg::ST_Z2P-1].ln[l].acc);
        end
    end

    always_comb begin
        pipe_next[wmp_pkg::ST_Z2] = pipe_reg[wmp_pkg::ST_Z2-1];
        for (int l = 0; l < 2; l++) begin
            pipe_next[wmp_pkg::ST_Z2].ln[l].aux =
                wmp_pkg::mul_shr(pipe_reg[wmp_pkg::ST_Z2-1].ln[l].pm, wmp_pkg::QF);
            pipe_next[wmp_pkg::ST_Z2].ln[l].t   = pipe_reg[wmp_pkg::ST_Z2-1].ln[l].acc;
            pipe_next[wmp_pkg::ST_Z2].ln[l].acc = 64'd0;
        end
    end

    // atanh odd series, three stages per term
    for (genvar gi = 0; gi < wmp_pkg::ATANH_TERMS; gi++) begin : g_ath
        localparam int unsigned DA   = 2 * gi + 1;
        localparam logic [63:0] RA   = 64'((128'd1 << 64) / DA);
        localparam int unsigned BASE = wmp_pkg::ST_ATH + gi * wmp_pkg::ATH_STG;

        always_comb begin
            pipe_next[BASE] = pipe_reg[BASE-1];
            for (int l = 0; l < 2; l++) begin
                pipe_next[BASE].ln[l].pm =
                    wmp_pkg::pp_calc(pipe_reg[BASE-1].ln[l].t, pipe_reg[BASE-1].ln[l].aux);
                pipe_next[BASE].ln[l].pd = wmp_pkg::pp_calc(pipe_reg[BASE-1].ln[l].t, RA);
            end
        end

        always_comb begin
            logic [127:0] f;
            pipe_next[BASE+1] = pipe_reg[BASE];
            for (int l = 0; l < 2; l++) begin
                pipe_next[BASE+1].ln[l].q =
                    wmp_pkg::mul_shr(pipe_reg[BASE].ln[l].pm, wmp_pkg::QF);
                f = wmp_pkg::pp_sum(pipe_reg[BASE].ln[l].pd);
                pipe_next[BASE+1].ln[l].e = f[127:64];
            end
        end

        always_comb begin
            logic [63:0] qt, rem;
            pipe_next[BASE+2] = pipe_reg[BASE+1];
            for (int l = 0; l < 2; l++) begin
                if (DA == 1) begin
                    qt = pipe_reg[BASE+1].ln[l].t;
                end else begin
                    rem = pipe_reg[BASE+1].ln[l].t - pipe_reg[BASE+1].ln[l].e * 64'(DA);
                    qt  = pipe_reg[BASE+1].ln[l].e + {63'd0, rem >= 64'(DA)};
                end
                pipe_next[BASE+2].ln[l].acc = pipe_reg[BASE+1].ln[l].acc + qt;
                pipe_next[BASE+2].ln[l].t   = pipe_reg[BASE+1].ln[l].q;
            end
        end
    end

    // ln(1+sin) - ln(cos), floored at zero
    always_comb begin
        logic [63:0] pos, lnv;
        pipe_next[wmp_pkg::ST_G] = pipe_reg[wmp_pkg::ST_G-1];
        pos = (pipe_reg[wmp_pkg::ST_G-1].ln[0].acc << 1) + pipe_reg[wmp_pkg::ST_G-1].kln2;
        lnv = pipe_reg[wmp_pkg::ST_G-1].ln[1].acc << 1;
        pipe_next[wmp_pkg::ST_G].ln[0].t = (pos > lnv) ? (pos - lnv) : 64'd0;
    end

    always_comb begin
        pipe_next[wmp_pkg::ST_YP] = pipe_reg[wmp_pkg::ST_YP-1];
        pipe_next[wmp_pkg::ST_YP].ln[0].pm =
            wmp_pkg::pp_calc(pipe_reg[wmp_pkg::ST_YP-1].ln[0].t, wmp_pkg::EARTH_R);
    end

    always_comb begin
        pipe_next[wmp_pkg::ST_Y] = pipe_reg[wmp_pkg::ST_Y-1];
        pipe_next[wmp_pkg::ST_Y].ln[0].t = {31'd0, wmp_pkg::rnd_sat(
            wmp_pkg::mul_shr(pipe_reg[wmp_pkg::ST_Y-1].ln[0].pm, wmp_pkg::Y_SHIFT))};
    end

    // sign application and packing
    always_comb begin
        logic [33:0] xm, ym, xs, ys;
        xm = {1'b0, pipe_reg[wmp_pkg::NST-1].x_mag};
        ym = {1'b0, pipe_reg[wmp_pkg::NST-1].ln[0].t[32:0]};
        xs = pipe_reg[wmp_pkg::NST-1].lon_neg ? (34'd0 - xm) : xm;
        ys = pipe_reg[wmp_pkg::NST-1].lat_neg ? (34'd0 - ym) : ym;
        m_tdata_next = {4'd0, ys, xs};
        m_tuser_next = pipe_reg[wmp_pkg::NST-1].clamped;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `WMP_ASSERT_NXT(a_reset_clears_out, aclk, 1'b0, !aresetn, !m_tvalid_reg, "output valid after reset")
    `WMP_ASSERT_IMP(a_stall_only_when_held, aclk, !aresetn, !s_tready, m_tvalid_reg && !m_tready, "input stalled while output free")
    `WMP_ASSERT_IMP(a_clamp_nonzero_y, aclk, !aresetn, m_tvalid_reg && m_tuser_reg, m_tdata_reg[67:34] != 34'd0, "clamped latitude gave zero northing")

endmodule
